// ===== rtl/core/gtr_pkg.sv =====
package gtr_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  // Action codes of an input word.
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Characters the front end recognises or the back end writes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Fixed strings, left-justified in a 13-character field.
  localparam int unsigned StrW = 104;
  localparam logic [StrW-1:0] S_DOTSTAR  = {".*", 88'h0};
  localparam logic [StrW-1:0] S_STAR_EL  = "([^./][^/]*)?";
  localparam logic [StrW-1:0] S_STAR     = {"[^/]*", 64'h0};
  localparam logic [StrW-1:0] S_QMARK_EL = {"[^./]", 64'h0};
  localparam logic [StrW-1:0] S_QMARK    = {"[^/]", 72'h0};

  typedef enum logic [2:0] {
    TK_NONE,
    TK_CHAR,
    TK_ESC,
    TK_STR,
    TK_CLOSE,
    TK_ERROR
  } tok_kind_e;

  typedef enum logic [2:0] {
    SID_DOTSTAR,
    SID_STAR_EL,
    SID_STAR,
    SID_QMARK_EL,
    SID_QMARK
  } str_id_e;

  // One decoded item: optional "^(" prefix, flushed dots, then one token.
  typedef struct packed {
    logic      prefix;
    logic [1:0] dots;
    tok_kind_e kind;
    str_id_e   sid;
    logic [7:0] ch;
    logic [4:0] len;
  } job_t;

  function automatic logic [4:0] tok_len(tok_kind_e kind, str_id_e sid);
    logic [4:0] n;
    n = 5'd0;
    unique case (kind)
      TK_CHAR, TK_ERROR: n = 5'd1;
      TK_ESC, TK_CLOSE:  n = 5'd2;
      TK_STR: begin
        unique case (sid)
          SID_DOTSTAR:  n = 5'd2;
          SID_STAR_EL:  n = 5'd13;
          SID_STAR:     n = 5'd5;
          SID_QMARK_EL: n = 5'd5;
          SID_QMARK:    n = 5'd4;
          default:      n = 5'd0;
        endcase
      end
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] str_char(str_id_e sid, logic [3:0] k);
    logic [StrW-1:0] s;
    logic [StrW-1:0] sh;
    s = S_DOTSTAR;
    unique case (sid)
      SID_DOTSTAR:  s = S_DOTSTAR;
      SID_STAR_EL:  s = S_STAR_EL;
      SID_STAR:     s = S_STAR;
      SID_QMARK_EL: s = S_QMARK_EL;
      SID_QMARK:    s = S_QMARK;
      default:      s = S_DOTSTAR;
    endcase
    sh = s << {k, 3'b000};
    return sh[StrW-1 -: 8];
  endfunction

endpackage

// ===== rtl/core/glob_to_regex_translator.sv =====
// Streams glob pattern characters in and regular-expression text out, one
// character per result word, framed by "^(" and ")$"; an end word closes each
// pattern and a slash or end inside a bracket class gives one zero character
// with syntax_error set. The front end classifies a glob character in the
// cycle it is pushed and places a decoded word in a four-entry queue, so
// input is taken every cycle while that queue has room. The back end then
// writes the expansion one character per cycle through its output register
// while that register is empty or being popped. An item produces no
// character for a held dot past the start of a pattern, one or two for most
// characters and up to fifteen for a star at the start of a pattern. run_last
// marks the final result of each item.
module glob_to_regex_translator import gtr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] glob_char_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       syntax_error_o
);

  logic accept;
  logic job_valid;
  job_t job_in;
  job_t job_out;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic out_empty;

  assign full   = q_full;
  assign accept = push && !q_full;

  gtr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .glob_char_i (glob_char_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  gtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gtr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_out),
    .job_empty_i    (q_empty),
    .job_pop_o      (q_pop),
    .pop_i          (pop && !out_empty),
    .empty_o        (out_empty),
    .out_char_o     (out_char_o),
    .run_last_o     (run_last_o),
    .syntax_error_o (syntax_error_o)
  );

  assign empty = out_empty;

endmodule

// ===== rtl/core/gtr_front.sv =====
module gtr_front import gtr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       action_i,
  input  logic [7:0] glob_char_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_NORMAL      = 3'd1;
  localparam logic [2:0] PH_CLASS_FIRST = 3'd2;
  localparam logic [2:0] PH_CLASS       = 3'd3;
  localparam logic [2:0] PH_ERROR       = 3'd4;

  logic [2:0] phase_q, phase_d;
  logic       es_q, es_d;
  logic [1:0] pd_q, pd_d;

  logic       in_run;
  logic       es_e;
  logic       es_f;
  logic [1:0] pd_e;
  logic [7:0] c;
  tok_kind_e  kind;
  str_id_e    sid;
  logic [7:0] tch;
  logic [1:0] dots;
  logic       prefix;
  logic       is_meta;

  assign c = glob_char_i;
  assign is_meta = (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_PIPE) || (c == CH_CARET) ||
                   (c == CH_DOLLAR) || (c == CH_RBRK) || (c == CH_PLUS) || (c == CH_BSLASH);

  // A bracket class character: closes, errors, is escaped, or passes through.
  function automatic void class_char(input logic [7:0] cc, output tok_kind_e k,
                                     output logic [7:0] t, output logic [2:0] ph,
                                     output logic clr_es);
    k = TK_CHAR;
    t = cc;
    ph = PH_CLASS;
    clr_es = 1'b0;
    if (cc == CH_RBRK) begin
      ph = PH_NORMAL;
      clr_es = 1'b1;
    end else if (cc == CH_SLASH) begin
      k = TK_ERROR;
      ph = PH_ERROR;
    end else if (cc == CH_CARET || cc == CH_BSLASH) begin
      k = TK_ESC;
    end
  endfunction

  always_comb begin
    logic [2:0] cph;
    logic       clr;
    phase_d = phase_q;
    es_d    = es_q;
    pd_d    = pd_q;
    kind    = TK_NONE;
    sid     = SID_DOTSTAR;
    tch     = c;
    dots    = 2'd0;
    prefix  = 1'b0;
    cph     = PH_CLASS;
    clr     = 1'b0;
    in_run  = (phase_q == PH_NORMAL) || (phase_q == PH_CLASS_FIRST) ||
              (phase_q == PH_CLASS);
    es_e    = in_run ? es_q : 1'b1;
    pd_e    = in_run ? pd_q : 2'd0;
    // Flushing held dots ends the path element.
    es_f    = (pd_e != 2'd0) ? 1'b0 : es_e;

    if (phase_q == PH_ERROR) begin
      if (action_i == ACT_END) begin
        kind    = TK_ERROR;
        phase_d = PH_START;
        es_d    = 1'b1;
        pd_d    = 2'd0;
      end
    end else begin
      prefix = !in_run;
      if (!in_run) begin
        phase_d = PH_NORMAL;
        es_d    = 1'b1;
        pd_d    = 2'd0;
      end
      if (action_i == ACT_END) begin
        if (!in_run || phase_q == PH_NORMAL) begin
          dots = pd_e;
          kind = TK_CLOSE;
        end else begin
          kind = TK_ERROR;
        end
        phase_d = PH_START;
        es_d    = 1'b1;
        pd_d    = 2'd0;
      end else if (!in_run || phase_q == PH_NORMAL) begin
        if (c == CH_DOT) begin
          if (pd_e == 2'd2) begin
            kind = TK_STR;
            sid  = SID_DOTSTAR;
            pd_d = 2'd0;
            es_d = 1'b0;
          end else begin
            pd_d = pd_e + 2'd1;
          end
        end else begin
          dots = pd_e;
          pd_d = 2'd0;
          es_d = 1'b0;
          if (c == CH_STAR) begin
            kind = TK_STR;
            sid  = es_f ? SID_STAR_EL : SID_STAR;
          end else if (c == CH_QMARK) begin
            kind = TK_STR;
            sid  = es_f ? SID_QMARK_EL : SID_QMARK;
          end else if (c == CH_LBRK) begin
            kind    = TK_CHAR;
            phase_d = PH_CLASS_FIRST;
            es_d    = es_f;
          end else if (c == CH_SLASH) begin
            kind = TK_CHAR;
            es_d = 1'b1;
          end else if (is_meta) begin
            kind = TK_ESC;
          end else begin
            kind = TK_CHAR;
          end
        end
      end else if (phase_q == PH_CLASS_FIRST && c == CH_TILDE) begin
        kind    = TK_CHAR;
        tch     = CH_CARET;
        phase_d = PH_CLASS;
      end else begin
        class_char(c, kind, tch, cph, clr);
        phase_d = cph;
        if (clr) begin
          es_d = 1'b0;
        end
      end
    end
  end

  assign job_o.prefix = prefix;
  assign job_o.dots   = dots;
  assign job_o.kind   = kind;
  assign job_o.sid    = sid;
  assign job_o.ch     = tch;
  assign job_o.len    = {3'b000, prefix, 1'b0} + {2'b00, dots, 1'b0} + tok_len(kind, sid);
  // A held dot at the start of a pattern still owes the "^(" prefix.
  assign job_valid_o  = accept_i && ((kind != TK_NONE) || prefix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      es_q    <= 1'b1;
      pd_q    <= 2'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      es_q    <= es_d;
      pd_q    <= pd_d;
    end
  end

endmodule

// ===== rtl/core/gtr_queue.sv =====
module gtr_queue import gtr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q;
  logic [QPtrW-1:0]  rd_q;
  logic [QPtrW:0]    cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPtrW + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/gtr_back.sv =====
module gtr_back import gtr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_empty_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_char_o,
  output logic       run_last_o,
  output logic       syntax_error_o
);

  job_t       cur_q;
  logic       busy_q;
  logic [4:0] idx_q;
  logic       ov_q;
  logic [7:0] och_q;
  logic       olast_q;
  logic       oerr_q;

  logic       adv;
  logic       last;
  logic       load;
  logic [4:0] plen;
  logic [4:0] dlen;
  logic [4:0] j;
  logic [4:0] k;
  logic [7:0] ch;
  logic       err;

  assign adv  = busy_q && (!ov_q || pop_i);
  assign last = (idx_q == cur_q.len - 5'd1);
  assign load = (!busy_q || (adv && last)) && !job_empty_i;
  assign job_pop_o = load;

  assign plen = {3'b000, cur_q.prefix, 1'b0};
  assign dlen = {2'b00, cur_q.dots, 1'b0};
  assign j    = idx_q - plen;
  assign k    = j - dlen;

  // Character at the current position: prefix, then "\." pairs, then the token.
  always_comb begin
    ch  = CH_NUL;
    err = 1'b0;
    if (idx_q < plen) begin
      ch = idx_q[0] ? CH_LPAR : CH_CARET;
    end else if (j < dlen) begin
      ch = j[0] ? CH_DOT : CH_BSLASH;
    end else begin
      unique case (cur_q.kind)
        TK_CHAR:  ch = cur_q.ch;
        TK_ESC:   ch = (k == 5'd0) ? CH_BSLASH : cur_q.ch;
        TK_STR:   ch = str_char(cur_q.sid, k[3:0]);
        TK_CLOSE: ch = (k == 5'd0) ? CH_RPAR : CH_DOLLAR;
        TK_ERROR: err = 1'b1;
        default:  ch = CH_NUL;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      och_q   <= ch;
      olast_q <= last;
      oerr_q  <= err;
    end
    if (load) begin
      cur_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (adv) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        idx_q <= idx_q + 5'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign empty_o        = !ov_q;
  assign out_char_o     = och_q;
  assign run_last_o     = olast_q;
  assign syntax_error_o = oerr_q;

`ifndef NO_ASSERTIONS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < cur_q.len))
    else $error("character index beyond current word length");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oerr_q) |-> (olast_q && och_q == CH_NUL))
    else $error("error result must be a lone zero character");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last && job_empty_i) |=> !busy_q)
    else $error("back end still busy after finishing with no queued word");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !job_empty_i) |=> busy_q)
    else $error("queued word not picked up by idle back end");
`endif

endmodule
